@@ sv/jpst_pkg.sv @@
package jpst_pkg;

  // Width of the array index accumulator.
  localparam int INDEX_BITS = 64;

  typedef logic [7:0] char_t;
  typedef logic [1:0] kind_t;
  typedef logic [2:0] err_t;

  // Result kinds.
  localparam kind_t KIND_CHAR  = 2'd0;
  localparam kind_t KIND_END   = 2'd1;
  localparam kind_t KIND_ERROR = 2'd2;

  // Error codes.
  localparam err_t ERR_MISSING_SLASH = 3'd0;
  localparam err_t ERR_INCOMPLETE_ESC = 3'd1;
  localparam err_t ERR_BAD_ESC       = 3'd2;
  localparam err_t ERR_LEADING_DOT   = 3'd3;
  localparam err_t ERR_BAD_BRACKET   = 3'd4;

  typedef struct packed {
    kind_t result_kind;
    char_t seg_char;
    logic  type_hint;
    err_t  error_code;
    logic  last_result;
  } result_t;

endpackage

@@ sv/jpst_if.sv @@
interface jpst_in_if
  import jpst_pkg::*;
  ();
  logic  valid;
  logic  ready;
  char_t path_char;
  logic  path_end;

  modport source (output valid, path_char, path_end, input ready);
  modport sink (input valid, path_char, path_end, output ready);
endinterface

interface jpst_out_if
  import jpst_pkg::*;
  ();
  logic  valid;
  logic  ready;
  kind_t result_kind;
  char_t seg_char;
  logic  type_hint;
  err_t  error_code;
  logic  last_result;

  modport source (output valid, result_kind, seg_char, type_hint, error_code, last_result,
                  input ready);
  modport sink (input valid, result_kind, seg_char, type_hint, error_code, last_result,
                output ready);
endinterface

@@ sv/json_path_segment_tokenizer.sv @@
// Channel     Dir  Beat contents                                     Handshake
// path        in   path_char[7:0], path_end                          valid/ready
// result      out  result_kind, seg_char, type_hint, error_code,     valid/ready
//                  last_result
// cfg         in   cfg_data (path_mode)                              cfg_we, no wait
//
// Each input beat is decoded in the cycle it is accepted; its 0..2 results land
// in a 4-entry result queue that drives result. One input beat per cycle while
// the queue has room, so one beat per cycle end to end while each byte makes at
// most one result and result.ready stays high; a byte with two results adds a
// result to the backlog (the queue pops one a cycle). path.ready is high while
// the queue has room for two results, so input keeps flowing while a result
// waits to be taken. Reset (rst, synchronous) empties the queue, returns the
// parser to segment start and sets path_mode to pointer syntax.
module json_path_segment_tokenizer
  import jpst_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_data,
  jpst_in_if.sink      path,
  jpst_out_if.source   result
);

  // Parser phases.
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_PSEG   = 3'd1;
  localparam logic [2:0] PH_PESC   = 3'd2;
  localparam logic [2:0] PH_QOBJ   = 3'd3;
  localparam logic [2:0] PH_QBRK   = 3'd4;
  localparam logic [2:0] PH_QAFTER = 3'd5;
  localparam logic [2:0] PH_DROP   = 3'd6;

  localparam char_t CH_SLASH = 8'h2F;
  localparam char_t CH_TILDE = 8'h7E;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_ONE   = 8'h31;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_DASH  = 8'h2D;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_LBRK  = 8'h5B;
  localparam char_t CH_RBRK  = 8'h5D;

  localparam int WIDE_BITS = INDEX_BITS + 4;

  // Per-segment tracking for the array-index rule.
  typedef struct packed {
    logic                  all_digits;
    logic                  seg_nonempty;
    logic                  is_lone_dash;
    logic [INDEX_BITS-1:0] index_value;
    logic                  index_overflow;
  } seg_t;

  localparam seg_t SEG_CLEAR = '{all_digits: 1'b1, seg_nonempty: 1'b0, is_lone_dash: 1'b0,
                                 index_value: '0, index_overflow: 1'b0};

  function automatic logic is_digit(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Value*10 + digit; overflow when the wide sum leaves INDEX_BITS.
  function automatic seg_t seg_append(input seg_t s, input char_t c);
    seg_t                 r;
    logic [WIDE_BITS-1:0] wide;
    r = s;
    r.is_lone_dash = !s.seg_nonempty && (c == CH_DASH);
    wide = ({4'b0, s.index_value} << 3) + ({4'b0, s.index_value} << 1)
         + WIDE_BITS'(c - CH_ZERO);
    if (is_digit(c)) begin
      if (!s.index_overflow) begin
        if (wide[WIDE_BITS-1:INDEX_BITS] != 4'd0) begin
          r.index_overflow = 1'b1;
        end else begin
          r.index_value = wide[INDEX_BITS-1:0];
        end
      end
    end else begin
      r.all_digits = 1'b0;
    end
    r.seg_nonempty = 1'b1;
    return r;
  endfunction

  function automatic logic ptr_hint(input seg_t s, input logic at_end);
    return (s.seg_nonempty && s.all_digits && !s.index_overflow) ||
           (s.is_lone_dash && at_end);
  endfunction

  function automatic result_t mk_res(input kind_t k, input char_t ch, input logic h,
                                     input err_t e);
    result_t r;
    r.result_kind = k;
    r.seg_char    = ch;
    r.type_hint   = h;
    r.error_code  = e;
    r.last_result = 1'b0;
    return r;
  endfunction

  // Parser state
  logic       path_mode;
  logic [2:0] phase;
  seg_t       seg;

  // Result queue
  result_t    queue [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  logic       in_fire;
  logic       out_fire;

  // Decode outputs
  logic [2:0] phase_next;
  seg_t       seg_next;
  result_t    res [2];
  logic [1:0] n_res;

  assign path.ready   = (count <= 3'd2);
  assign in_fire      = path.valid && path.ready;
  assign result.valid = (count != 3'd0);
  assign out_fire     = result.valid && result.ready;

  always_comb begin
    char_t      c;
    logic       at_end;
    logic       do_start;
    logic [2:0] ph;
    seg_t       s;
    logic [1:0] n;
    result_t    r [2];

    c        = path.path_char;
    at_end   = path.path_end;
    do_start = 1'b0;
    ph       = phase;
    s        = seg;
    n        = 2'd0;
    r[0]     = '0;
    r[1]     = '0;

    case (phase)
      PH_PSEG: begin
        if (c == CH_SLASH) begin
          r[n[0]] = mk_res(KIND_END, '0, ptr_hint(s, 1'b0), '0); n = n + 2'd1;
          s = SEG_CLEAR;
          if (at_end) begin
            r[n[0]] = mk_res(KIND_END, '0, ptr_hint(s, 1'b1), '0); n = n + 2'd1;
          end
        end else if (c == CH_TILDE) begin
          if (at_end) begin
            r[n[0]] = mk_res(KIND_ERROR, '0, 1'b0, ERR_INCOMPLETE_ESC); n = n + 2'd1;
            ph = PH_DROP;
          end else begin
            ph = PH_PESC;
          end
        end else begin
          s = seg_append(s, c);
          r[n[0]] = mk_res(KIND_CHAR, c, 1'b0, '0); n = n + 2'd1;
          if (at_end) begin
            r[n[0]] = mk_res(KIND_END, '0, ptr_hint(s, 1'b1), '0); n = n + 2'd1;
          end
        end
      end
      PH_PESC: begin
        if (c == CH_ZERO || c == CH_ONE) begin
          s = seg_append(s, (c == CH_ZERO) ? CH_TILDE : CH_SLASH);
          r[n[0]] = mk_res(KIND_CHAR, (c == CH_ZERO) ? CH_TILDE : CH_SLASH, 1'b0, '0);
          n = n + 2'd1;
          ph = PH_PSEG;
          if (at_end) begin
            r[n[0]] = mk_res(KIND_END, '0, ptr_hint(s, 1'b1), '0); n = n + 2'd1;
          end
        end else begin
          r[n[0]] = mk_res(KIND_ERROR, '0, 1'b0, ERR_BAD_ESC); n = n + 2'd1;
          ph = PH_DROP;
        end
      end
      PH_QOBJ: begin
        if (c == CH_DOT) begin
          r[n[0]] = mk_res(KIND_END, '0, 1'b0, '0); n = n + 2'd1;
          ph = PH_START;
        end else if (c == CH_LBRK) begin
          r[n[0]] = mk_res(KIND_END, '0, 1'b0, '0); n = n + 2'd1;
          s = SEG_CLEAR;
          ph = PH_QBRK;
          if (at_end) begin
            r[n[0]] = mk_res(KIND_ERROR, '0, 1'b0, ERR_BAD_BRACKET); n = n + 2'd1;
            ph = PH_DROP;
          end
        end else begin
          s = seg_append(s, c);
          r[n[0]] = mk_res(KIND_CHAR, c, 1'b0, '0); n = n + 2'd1;
          if (at_end) begin
            r[n[0]] = mk_res(KIND_END, '0, 1'b0, '0); n = n + 2'd1;
          end
        end
      end
      PH_QBRK: begin
        if (is_digit(c)) begin
          s = seg_append(s, c);
          r[n[0]] = mk_res(KIND_CHAR, c, 1'b0, '0); n = n + 2'd1;
          if (at_end) begin
            r[n[0]] = mk_res(KIND_ERROR, '0, 1'b0, ERR_BAD_BRACKET); n = n + 2'd1;
            ph = PH_DROP;
          end
        end else if (c == CH_RBRK) begin
          r[n[0]] = mk_res(KIND_END, '0, 1'b1, '0); n = n + 2'd1;
          ph = PH_QAFTER;
        end else begin
          r[n[0]] = mk_res(KIND_ERROR, '0, 1'b0, ERR_BAD_BRACKET); n = n + 2'd1;
          ph = PH_DROP;
        end
      end
      PH_QAFTER: begin
        // one optional dot after a bracket is swallowed
        if (c == CH_DOT) begin
          ph = PH_START;
        end else begin
          do_start = 1'b1;
        end
      end
      PH_DROP: begin
        ph = PH_DROP;
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // Segment start; mode is sampled only here.
    if (do_start) begin
      if (!path_mode) begin
        if (c != CH_SLASH) begin
          r[n[0]] = mk_res(KIND_ERROR, '0, 1'b0, ERR_MISSING_SLASH); n = n + 2'd1;
          ph = PH_DROP;
        end else begin
          s = SEG_CLEAR;
          ph = PH_PSEG;
          if (at_end) begin
            r[n[0]] = mk_res(KIND_END, '0, ptr_hint(s, 1'b1), '0); n = n + 2'd1;
          end
        end
      end else if (c == CH_DOT) begin
        r[n[0]] = mk_res(KIND_ERROR, '0, 1'b0, ERR_LEADING_DOT); n = n + 2'd1;
        ph = PH_DROP;
      end else if (c == CH_LBRK) begin
        s = SEG_CLEAR;
        ph = PH_QBRK;
        if (at_end) begin
          r[n[0]] = mk_res(KIND_ERROR, '0, 1'b0, ERR_BAD_BRACKET); n = n + 2'd1;
          ph = PH_DROP;
        end
      end else begin
        s = seg_append(SEG_CLEAR, c);
        r[n[0]] = mk_res(KIND_CHAR, c, 1'b0, '0); n = n + 2'd1;
        ph = PH_QOBJ;
        if (at_end) begin
          r[n[0]] = mk_res(KIND_END, '0, 1'b0, '0); n = n + 2'd1;
        end
      end
    end

    // every path end returns to segment start
    if (at_end) begin
      ph = PH_START;
    end

    r[0].last_result = (n == 2'd1);
    r[1].last_result = (n == 2'd2);

    phase_next = ph;
    seg_next   = s;
    res        = r;
    n_res      = n;
  end

  // Parser state and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      path_mode <= 1'b0;
      phase     <= PH_START;
      seg       <= SEG_CLEAR;
    end else begin
      if (cfg_we) begin
        path_mode <= cfg_data;
      end
      if (in_fire) begin
        phase <= phase_next;
        seg   <= seg_next;
      end
    end
  end

  // Result queue: up to two pushes and one pop a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + n_res;
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (in_fire ? {1'b0, n_res} : 3'd0) - {2'b0, out_fire};
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && n_res != 2'd0) begin
      queue[wr_ptr] <= res[0];
    end
    if (in_fire && n_res == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res[1];
    end
  end

  assign result.result_kind = queue[rd_ptr].result_kind;
  assign result.seg_char    = queue[rd_ptr].seg_char;
  assign result.type_hint   = queue[rd_ptr].type_hint;
  assign result.error_code  = queue[rd_ptr].error_code;
  assign result.last_result = queue[rd_ptr].last_result;

endmodule
